>>> rtl/core/b64u_pkg.sv
// Shared types, constants and the character map for the base64url decoder.
`timescale 1ns / 1ps

package b64u_pkg;

   // ASCII bounds of the alphabet ranges
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_DASH = 8'h2D;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

   // Sextet offsets and fixed codes
   localparam logic [5:0] OFS_LOWER = 6'd26;
   localparam logic [5:0] OFS_DIGIT = 6'd52;
   localparam logic [5:0] SEXTET_DASH = 6'd62;
   localparam logic [5:0] SEXTET_UNDERSCORE = 6'd63;

   // Unused bits of the last sextet in a tail of two / three
   localparam logic [5:0] TAIL2_PAD_MASK = 6'h0F;
   localparam logic [5:0] TAIL3_PAD_MASK = 6'h03;

   // Sextets pending in the current group
   localparam logic [1:0] POS_ZERO = 2'd0;
   localparam logic [1:0] POS_ONE = 2'd1;
   localparam logic [1:0] POS_TWO = 2'd2;
   localparam logic [1:0] POS_THREE = 2'd3;

   // One input transaction
   typedef struct packed {
      logic [7:0] character;
      logic       has_char;
      logic       end_of_message;
   } b64u_item_type;

   // Results produced by one input transaction (count 0..3)
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
      logic            has_bytes;
      logic            last;
      logic            bad;
   } b64u_group_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } b64u_sextet_type;

   // Character to sextet; ok is low outside the alphabet
   function automatic b64u_sextet_type map_char(input logic [7:0] c);
      b64u_sextet_type r;
      logic [7:0]      d;
      r.ok = 1'b1;
      r.value = '0;
      d = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d = c - CHAR_UPPER_A;
         r.value = d[5:0];
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d = c - CHAR_LOWER_A;
         r.value = d[5:0] + OFS_LOWER;
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         d = c - CHAR_DIGIT_0;
         r.value = d[5:0] + OFS_DIGIT;
      end else if (c == CHAR_DASH) begin
         r.value = SEXTET_DASH;
      end else if (c == CHAR_UNDERSCORE) begin
         r.value = SEXTET_UNDERSCORE;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

>>> rtl/core/base64url_strict_decoder.sv
// Top level of the strict unpadded base64url decoder.
// Path: a transaction is registered in the input register, then moves into the result
// register once that frees up; results are driven from the result register.
// Throughput: one transaction per cycle while the result register can take it; a transaction
// that yields k results holds the result register until all k of them are taken.
// Reset: synchronous; clears decode state and the input and result valid flags.
`timescale 1ns / 1ps

module base64url_strict_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_character,
   input  logic       req_has_char,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_final_res,
   output logic       rsp_bad_message
);

   b64u_pkg::b64u_item_type  in_ff;
   logic                     in_valid_ff, in_valid_in;
   b64u_pkg::b64u_group_type group;
   logic                     load_ok;
   logic                     move;
   logic                     req_take;

   // Input register hands over whenever the result register frees up
   assign move = in_valid_ff && load_ok;
   assign req_stall = in_valid_ff && !load_ok;
   assign req_take = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (move) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= {req_character, req_has_char, req_end_of_message};
      end
   end

   b64u_dec_core u_core (
      .clock (clock),
      .reset (reset),
      .load  (move),
      .item  (in_ff),
      .group (group)
   );

   b64u_out_seq u_out (
      .clock           (clock),
      .reset           (reset),
      .load            (move),
      .group           (group),
      .load_ok         (load_ok),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_final_res   (rsp_final_res),
      .rsp_bad_message (rsp_bad_message)
   );

`ifndef SYNTHESIS
   // A rejected message only shows as a status result that closes it
   a_bad_is_final_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_message |-> rsp_final_res && !rsp_byte_valid)
      else $error("bad_message on a non-final or byte-carrying result");

   // Status-only results occur only at the end of a message
   a_status_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_final_res)
      else $error("status-only result before end of message");

   // Input side backs up only with a transaction held in the input register
   a_stall_needs_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid)
      else $error("input stalled with nothing held");
`endif

endmodule

>>> rtl/core/b64u_dec_core.sv
// Decode state (accumulator, group position, error) and per-transaction result group.
`timescale 1ns / 1ps

module b64u_dec_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  b64u_pkg::b64u_item_type  item,
   output b64u_pkg::b64u_group_type group
);

   logic [17:0] acc_ff, acc_in;
   logic [1:0]  pos_ff, pos_in;
   logic        err_ff, err_in;

   b64u_pkg::b64u_sextet_type sx;
   logic [23:0]     bits;
   logic [17:0]     acc1;
   logic [1:0]      pos1;
   logic            err1;
   logic            err2;
   logic [2:0][7:0] bytes_w;
   logic [1:0]      nbytes;

   assign sx = b64u_pkg::map_char(item.character);
   assign bits = {acc_ff, sx.value};

   // Character step, then end-of-message tail check
   always_comb begin
      acc1 = acc_ff;
      pos1 = pos_ff;
      err1 = err_ff;
      bytes_w = '0;
      nbytes = 2'd0;
      if (item.has_char && !err_ff) begin
         if (!sx.ok) begin
            err1 = 1'b1;
         end else if (pos_ff == b64u_pkg::POS_THREE) begin
            bytes_w[0] = bits[23:16];
            bytes_w[1] = bits[15:8];
            bytes_w[2] = bits[7:0];
            nbytes = 2'd3;
            acc1 = '0;
            pos1 = b64u_pkg::POS_ZERO;
         end else begin
            acc1 = {acc_ff[11:0], sx.value};
            pos1 = pos_ff + 2'd1;
         end
      end

      err2 = err1;
      if (item.end_of_message && !err1) begin
         case (pos1)
            b64u_pkg::POS_ONE: begin
               err2 = 1'b1;
            end
            b64u_pkg::POS_TWO: begin
               if ((acc1[5:0] & b64u_pkg::TAIL2_PAD_MASK) != 6'd0) begin
                  err2 = 1'b1;
               end else begin
                  bytes_w[0] = acc1[11:4];
                  nbytes = 2'd1;
               end
            end
            b64u_pkg::POS_THREE: begin
               if ((acc1[5:0] & b64u_pkg::TAIL3_PAD_MASK) != 6'd0) begin
                  err2 = 1'b1;
               end else begin
                  bytes_w[0] = acc1[17:10];
                  bytes_w[1] = acc1[9:2];
                  nbytes = 2'd2;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Result group: bytes mid-message, or final bytes / status at the end
   always_comb begin
      group.bytes = bytes_w;
      group.count = nbytes;
      group.has_bytes = 1'b1;
      group.last = 1'b0;
      group.bad = 1'b0;
      if (item.end_of_message) begin
         group.last = 1'b1;
         if (err2 || nbytes == 2'd0) begin
            group.bytes = '0;
            group.count = 2'd1;
            group.has_bytes = 1'b0;
            group.bad = err2;
         end
      end
   end

   // State returns to reset after the end of a message
   always_comb begin
      if (item.end_of_message) begin
         acc_in = '0;
         pos_in = b64u_pkg::POS_ZERO;
         err_in = 1'b0;
      end else begin
         acc_in = acc1;
         pos_in = pos1;
         err_in = err1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         pos_ff <= b64u_pkg::POS_ZERO;
         err_ff <= 1'b0;
      end else if (load) begin
         acc_ff <= acc_in;
         pos_ff <= pos_in;
         err_ff <= err_in;
      end
   end

endmodule

>>> rtl/core/b64u_out_seq.sv
// Result register: holds one result group and sends its entries one per transaction.
`timescale 1ns / 1ps

module b64u_out_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  b64u_pkg::b64u_group_type group,
   output logic                     load_ok,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_data_byte,
   output logic                     rsp_byte_valid,
   output logic                     rsp_final_res,
   output logic                     rsp_bad_message
);

   b64u_pkg::b64u_group_type grp_ff;
   logic [1:0] rem_ff, rem_in;
   logic [1:0] idx_ff, idx_in;
   logic       taken;

   assign rsp_valid = (rem_ff != 2'd0);
   assign taken = rsp_valid && !rsp_stall;
   // Free when empty or the last pending entry leaves now
   assign load_ok = (rem_ff == 2'd0) || (taken && rem_ff == 2'd1);

   // Entry select
   always_comb begin
      case (idx_ff)
         2'd0: rsp_data_byte = grp_ff.bytes[0];
         2'd1: rsp_data_byte = grp_ff.bytes[1];
         2'd2: rsp_data_byte = grp_ff.bytes[2];
         default: rsp_data_byte = '0;
      endcase
   end

   assign rsp_byte_valid = grp_ff.has_bytes;
   assign rsp_final_res = grp_ff.last && (rem_ff == 2'd1);
   assign rsp_bad_message = grp_ff.bad && (rem_ff == 2'd1);

   // Pending count and read index
   always_comb begin
      rem_in = rem_ff;
      idx_in = idx_ff;
      if (load) begin
         rem_in = group.count;
         idx_in = 2'd0;
      end else if (taken) begin
         rem_in = rem_ff - 2'd1;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
         idx_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff <= group;
      end
   end

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the strict unpadded base64url decoder.
`timescale 1ns / 1ps

module testbench;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 8;
   localparam int TAIL_CYCLES = 12;
   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_ITEMS = 55;

   // One expected result transaction
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       final_res;
      logic       bad_message;
   } octet_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_character = 8'h00;
   logic       req_has_char = 1'b0;
   logic       req_end_of_message = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_data_byte;
   logic       rsp_byte_valid;
   logic       rsp_final_res;
   logic       rsp_bad_message;

   // Predictor state: pending sextets, count in group, message already failed
   logic [17:0] acc_bits = '0;
   logic [1:0]  group_pos = b64u_pkg::POS_ZERO;
   logic        msg_failed = 1'b0;

   octet_result_type pending_octets[$];

   int idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   int fail_count = 0;
   int items_sent = 0;
   int messages_done = 0;
   int results_checked = 0;
   int cycle_count = 0;

   base64url_strict_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_character      (req_character),
      .req_has_char       (req_has_char),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_final_res      (rsp_final_res),
      .rsp_bad_message    (rsp_bad_message)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Character to sextet; returns 0 outside the alphabet
   function automatic logic sextet_of(input logic [7:0] ch, output logic [5:0] s);
      logic [7:0] d;
      d = 8'h00;
      s = '0;
      if (ch >= b64u_pkg::CHAR_UPPER_A && ch <= b64u_pkg::CHAR_UPPER_Z) begin
         d = ch - b64u_pkg::CHAR_UPPER_A;
      end else if (ch >= b64u_pkg::CHAR_LOWER_A && ch <= b64u_pkg::CHAR_LOWER_Z) begin
         d = ch - b64u_pkg::CHAR_LOWER_A + 8'd26;
      end else if (ch >= b64u_pkg::CHAR_DIGIT_0 && ch <= b64u_pkg::CHAR_DIGIT_9) begin
         d = ch - b64u_pkg::CHAR_DIGIT_0 + 8'd52;
      end else if (ch == b64u_pkg::CHAR_DASH) begin
         d = 8'd62;
      end else if (ch == b64u_pkg::CHAR_UNDERSCORE) begin
         d = 8'd63;
      end else begin
         return 1'b0;
      end
      s = d[5:0];
      return 1'b1;
   endfunction

   // Sextet to alphabet character
   function automatic logic [7:0] char_of(input logic [5:0] s);
      if (s < 6'd26) return b64u_pkg::CHAR_UPPER_A + {2'b00, s};
      if (s < 6'd52) return b64u_pkg::CHAR_LOWER_A + {2'b00, s - 6'd26};
      if (s < 6'd62) return b64u_pkg::CHAR_DIGIT_0 + {2'b00, s - 6'd52};
      if (s == b64u_pkg::SEXTET_DASH) return b64u_pkg::CHAR_DASH;
      return b64u_pkg::CHAR_UNDERSCORE;
   endfunction

   // Append one expected result transaction
   task automatic queue_expected(input logic [7:0] b, input logic v, input logic f,
                                 input logic bad);
      octet_result_type r;
      r.data_byte = b;
      r.byte_valid = v;
      r.final_res = f;
      r.bad_message = bad;
      pending_octets = {pending_octets, r};
   endtask

   // Decode one accepted transaction and queue the octets it yields
   task automatic decode_transaction(input logic [7:0] ch, input logic has,
                                     input logic last);
      logic [7:0]  octets[3];
      logic [5:0]  s;
      logic [23:0] bits;
      int          n;
      n = 0;
      if (has && !msg_failed) begin
         if (!sextet_of(ch, s)) begin
            msg_failed = 1'b1;
         end else if (group_pos == b64u_pkg::POS_THREE) begin
            bits = {acc_bits, s};
            octets[0] = bits[23:16];
            octets[1] = bits[15:8];
            octets[2] = bits[7:0];
            n = 3;
            acc_bits = '0;
            group_pos = b64u_pkg::POS_ZERO;
         end else begin
            acc_bits = {acc_bits[11:0], s};
            group_pos = group_pos + 2'd1;
         end
      end
      // Tail handling at end of message
      if (last && !msg_failed) begin
         case (group_pos)
            b64u_pkg::POS_ONE: msg_failed = 1'b1;
            b64u_pkg::POS_TWO: begin
               if ((acc_bits[5:0] & b64u_pkg::TAIL2_PAD_MASK) != 0) msg_failed = 1'b1;
               else octets[n++] = acc_bits[11:4];
            end
            b64u_pkg::POS_THREE: begin
               if ((acc_bits[5:0] & b64u_pkg::TAIL3_PAD_MASK) != 0) begin
                  msg_failed = 1'b1;
               end else begin
                  octets[n++] = acc_bits[17:10];
                  octets[n++] = acc_bits[9:2];
               end
            end
            default: ;
         endcase
      end
      if (!last) begin
         for (int k = 0; k < n; k++) queue_expected(octets[k], 1'b1, 1'b0, 1'b0);
      end else begin
         if (msg_failed || n == 0) begin
            queue_expected(8'h00, 1'b0, 1'b1, msg_failed);
         end else begin
            for (int k = 0; k < n; k++)
               queue_expected(octets[k], 1'b1, k == n - 1, 1'b0);
         end
         acc_bits = '0;
         group_pos = b64u_pkg::POS_ZERO;
         msg_failed = 1'b0;
         messages_done++;
      end
   endtask

   // Check each result transaction, then predict from the accepted input
   always @(posedge clock) begin : monitor
      octet_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (pending_octets.size() == 0) begin
               $error("unexpected result transaction: data_byte %h byte_valid %b",
                      rsp_data_byte, rsp_byte_valid);
               fail_count++;
            end else begin
               want = pending_octets.pop_front();
               if (rsp_data_byte !== want.data_byte) begin
                  $error("data_byte: expected %h, actual %h", want.data_byte, rsp_data_byte);
                  fail_count++;
               end
               if (rsp_byte_valid !== want.byte_valid) begin
                  $error("byte_valid: expected %b, actual %b",
                         want.byte_valid, rsp_byte_valid);
                  fail_count++;
               end
               if (rsp_final_res !== want.final_res) begin
                  $error("final_res: expected %b, actual %b", want.final_res, rsp_final_res);
                  fail_count++;
               end
               if (rsp_bad_message !== want.bad_message) begin
                  $error("bad_message: expected %b, actual %b",
                         want.bad_message, rsp_bad_message);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            decode_transaction(req_character, req_has_char, req_end_of_message);
      end
   end

   // Receiver: long hold-off when requested, random stall otherwise
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Offer one transaction and wait until it is accepted; called at a falling edge
   task automatic send_item(input logic [7:0] ch, input logic has, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_character <= ch;
      req_has_char <= has;
      req_end_of_message <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string txt, input bit end_on_last);
      for (int i = 0; i < txt.len(); i++)
         send_item(txt[i], 1'b1, end_on_last && (i == txt.len() - 1));
   endtask

   // Stop offering and wait for every expected result
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_octets.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Alphabet extremes in full groups, end marker after a group, empty message
   task automatic test_alphabet_groups;
      idle_pct = 0;
      stall_pct = 0;
      send_text("AZaz", 1'b1);
      send_text("09-_", 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hFF, 1'b0, 1'b1);
      drain();
   endtask

   // Tails of one, two and three characters, with clean and dirty unused bits
   task automatic test_tails;
      send_text("QQ", 1'b1);
      send_text("QR", 1'b1);
      send_text("QUE", 1'b1);
      send_text("QUF", 1'b1);
      send_text("Q", 1'b1);
      drain();
   endtask

   // Characters outside the alphabet, characters after an error, ignored items
   task automatic test_invalid_chars;
      send_text("A=B", 1'b1);
      send_item(8'h41, 1'b0, 1'b0);
      send_item(8'hFF, 1'b1, 1'b1);
      send_text("QUJD", 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h7A, 1'b1, 1'b1);
      drain();
   endtask

   // Mostly well-formed messages with random content, some raw noise
   task automatic test_random_messages(input int count, input int send_idle,
                                       input int recv_stall);
      int         start;
      int         len;
      bit         sep_end;
      logic [5:0] s;
      start = items_sent;
      idle_pct = send_idle;
      stall_pct = recv_stall;
      while (items_sent - start < count) begin
         if ($urandom_range(99) < 85) begin
            len = $urandom_range(0, 14);
            sep_end = (len == 0) || ($urandom_range(1) == 1);
            for (int i = 0; i < len; i++) begin
               s = 6'($urandom_range(63));
               if (i == len - 1 && $urandom_range(99) < 80) begin
                  if (len % 4 == 2) s = s & ~b64u_pkg::TAIL2_PAD_MASK;
                  else if (len % 4 == 3) s = s & ~b64u_pkg::TAIL3_PAD_MASK;
               end
               send_item(char_of(s), 1'b1, (i == len - 1) && !sep_end);
            end
            if (sep_end) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
         end else begin
            repeat ($urandom_range(1, 6))
               send_item(8'($urandom_range(255)), 1'($urandom_range(1)),
                         $urandom_range(3) == 0);
         end
      end
      drain();
   endtask

   // Receiver holds off while the sender keeps offering, then a full pause
   task automatic test_backpressure;
      idle_pct = 0;
      stall_pct = 0;
      @(posedge clock);
      hold_left = 300;
      @(negedge clock);
      for (int i = 0; i < 48; i++)
         send_item(char_of(6'($urandom_range(63))), 1'b1, i == 47);
      drain();
      send_text("TWFu", 1'b1);
      drain();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_alphabet_groups();
      test_tails();
      test_invalid_chars();
      test_random_messages(RANDOM_ITEMS, 0, 0);
      test_random_messages(RANDOM_ITEMS, 63, 0);
      test_random_messages(RANDOM_ITEMS, 0, 63);
      test_random_messages(RANDOM_ITEMS, 8, 8);
      test_backpressure();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_octets.size() != 0) begin
         $error("%0d expected result transactions never arrived", pending_octets.size());
         fail_count++;
      end
      $display("Decoded %0d messages from %0d input transactions; %0d results checked.",
               messages_done, items_sent, results_checked);
      $display("Covered tails, bad characters, idle/stall phases and a long hold-off.");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
